FILE: src/smp_pkg.sv
// Shared types and constants for the SPI master port.
// Holds the command codes, configuration indexes and inter-module structs.
// No dependencies.
package smp_pkg;

  // Item kinds (tick or bus access) carried in the slave-side tuser
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_STATUS = 2'd3
  } smp_cmd_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_BAUD   = 3'd0;
  localparam logic [2:0] CFG_CPOL   = 3'd1;
  localparam logic [2:0] CFG_CPHA   = 3'd2;
  localparam logic [2:0] CFG_LSB    = 3'd3;
  localparam logic [2:0] CFG_WIDE   = 3'd4;
  localparam logic [2:0] CFG_ENABLE = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 3;
  localparam int unsigned WordW    = 16;
  localparam int unsigned PrescW   = 7;
  localparam int unsigned NarrowW  = 8;

  typedef struct packed {
    logic [2:0] baud_select;
    logic       clock_polarity;
    logic       clock_phase;
    logic       lsb_first;
    logic       wide_frame;
    logic       port_enable;
  } smp_cfg_t;

  typedef struct packed {
    logic             valid;
    smp_cmd_e         cmd;
    logic [WordW-1:0] write_word;
    logic             miso_bit;
  } smp_step_t;

  typedef struct packed {
    logic             overrun_flag;
    logic             busy_flag;
    logic             rx_not_empty;
    logic             tx_empty;
    logic             mosi_bit;
    logic             sck_level;
    logic [WordW-1:0] read_word;
  } smp_result_t;

endpackage

FILE: src/smp_engine.sv
// SPI master state and per-item step logic: buffers, shifter, prescaler, flags.
// Depends on smp_pkg. Result is combinational from current state and the item;
// the caller registers it.
module smp_engine #(
  parameter int unsigned MAX_FRAME_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smp_pkg::smp_cfg_t   cfg_i,
  input  smp_pkg::smp_step_t  step_i,
  output smp_pkg::smp_result_t result_o
);
  import smp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAME_BITS + 1);
  localparam int unsigned IdxW = $clog2(MAX_FRAME_BITS);

  logic [MAX_FRAME_BITS-1:0] tx_holding_q, tx_holding_d;
  logic                      tx_pending_q, tx_pending_d;
  logic [MAX_FRAME_BITS-1:0] shift_word_q, shift_word_d;
  logic [CntW-1:0]           bits_left_q, bits_left_d;
  logic [PrescW-1:0]         presc_q, presc_d;
  logic                      clock_level_q, clock_level_d;
  logic [MAX_FRAME_BITS-1:0] rx_holding_q, rx_holding_d;
  logic                      rx_full_q, rx_full_d;
  logic                      overrun_q, overrun_d;
  logic                      rd_armed_q, rd_armed_d;
  logic                      miso_latch_q, miso_latch_d;
  logic                      latch_valid_q, latch_valid_d;

  logic [MAX_FRAME_BITS-1:0] frame_mask;
  logic [IdxW-1:0]           top_idx;
  logic [CntW-1:0]           frame_len;
  logic [PrescW:0]           half;
  logic [PrescW:0]           presc_inc;
  logic                      do_edge;
  logic                      leading;
  logic                      capture;
  logic                      do_shift;
  logic                      shift_latch;
  logic [MAX_FRAME_BITS-1:0] w_masked;
  logic [MAX_FRAME_BITS-1:0] w_shifted;
  logic [MAX_FRAME_BITS-1:0] insert_bit;
  logic [CntW-1:0]           bits_dec;

  // Frame geometry from the current configuration
  assign frame_mask = cfg_i.wide_frame ? {MAX_FRAME_BITS{1'b1}}
                                       : MAX_FRAME_BITS'(8'hFF);
  assign top_idx    = cfg_i.wide_frame ? IdxW'(MAX_FRAME_BITS - 1) : IdxW'(NarrowW - 1);
  assign frame_len  = cfg_i.wide_frame ? CntW'(MAX_FRAME_BITS) : CntW'(NarrowW);
  assign half       = (PrescW + 1)'(1) << cfg_i.baud_select;
  assign presc_inc  = {1'b0, presc_q} + (PrescW + 1)'(1);

  // Next state for one item
  always_comb begin
    tx_holding_d  = tx_holding_q;
    tx_pending_d  = tx_pending_q;
    shift_word_d  = shift_word_q;
    bits_left_d   = bits_left_q;
    presc_d       = presc_q;
    clock_level_d = (bits_left_q == '0) ? cfg_i.clock_polarity : clock_level_q;
    rx_holding_d  = rx_holding_q;
    rx_full_d     = rx_full_q;
    overrun_d     = overrun_q;
    rd_armed_d    = rd_armed_q;
    miso_latch_d  = miso_latch_q;
    latch_valid_d = latch_valid_q;
    do_edge       = 1'b0;
    leading       = 1'b0;
    capture       = 1'b0;
    do_shift      = 1'b0;
    shift_latch   = miso_latch_q;
    w_masked      = shift_word_q & frame_mask;
    w_shifted     = w_masked;
    insert_bit    = '0;
    bits_dec      = bits_left_q - CntW'(1);

    if (step_i.valid) begin
      case (step_i.cmd)
        CMD_TICK: begin
          if (!cfg_i.port_enable) begin
            bits_left_d   = '0;
            latch_valid_d = 1'b0;
            presc_d       = '0;
            clock_level_d = cfg_i.clock_polarity;
          end else begin
            // Prescaler and SCK edge
            if (bits_left_q != '0) begin
              if (presc_inc >= half) begin
                presc_d = '0;
                do_edge = 1'b1;
              end else begin
                presc_d = presc_inc[PrescW-1:0];
              end
            end
            if (do_edge) begin
              leading       = (clock_level_d == cfg_i.clock_polarity);
              capture       = leading ? !cfg_i.clock_phase : cfg_i.clock_phase;
              clock_level_d = !clock_level_d;
              if (capture) begin
                miso_latch_d  = step_i.miso_bit;
                latch_valid_d = 1'b1;
                shift_latch   = step_i.miso_bit;
                do_shift      = cfg_i.clock_phase && (bits_left_q == CntW'(1));
              end else begin
                do_shift      = latch_valid_q;
              end
            end
            // Shift one bit in and out
            if (do_shift) begin
              insert_bit = '0;
              insert_bit[top_idx] = shift_latch;
              if (cfg_i.lsb_first) begin
                w_shifted = (w_masked >> 1) | insert_bit;
              end else begin
                w_shifted = ((w_masked << 1) | MAX_FRAME_BITS'(shift_latch)) & frame_mask;
              end
              shift_word_d  = w_shifted;
              latch_valid_d = 1'b0;
              bits_left_d   = bits_dec;
              if (bits_dec == '0) begin
                if (rx_full_q) begin
                  overrun_d = 1'b1;
                end else begin
                  rx_holding_d = w_shifted;
                  rx_full_d    = 1'b1;
                end
              end
            end
            // Start the next frame
            if (bits_left_d == '0 && tx_pending_q) begin
              shift_word_d  = tx_holding_q & frame_mask;
              tx_pending_d  = 1'b0;
              bits_left_d   = frame_len;
              latch_valid_d = 1'b0;
              presc_d       = '0;
              clock_level_d = cfg_i.clock_polarity;
            end
          end
        end
        CMD_WRITE: begin
          tx_holding_d = step_i.write_word[MAX_FRAME_BITS-1:0];
          tx_pending_d = 1'b1;
        end
        CMD_READ: begin
          rx_full_d = 1'b0;
          if (overrun_q) rd_armed_d = 1'b1;
        end
        CMD_STATUS: begin
          if (overrun_q && rd_armed_q) begin
            overrun_d  = 1'b0;
            rd_armed_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the item, flags after the update
  always_comb begin
    result_o.read_word    = (step_i.cmd == CMD_READ) ? WordW'(rx_holding_q) : '0;
    result_o.sck_level    = clock_level_d;
    if (bits_left_d == '0) begin
      result_o.mosi_bit   = 1'b0;
    end else if (cfg_i.lsb_first) begin
      result_o.mosi_bit   = shift_word_d[0];
    end else begin
      result_o.mosi_bit   = shift_word_d[top_idx];
    end
    result_o.tx_empty     = !tx_pending_d;
    result_o.rx_not_empty = rx_full_d;
    result_o.busy_flag    = (bits_left_d != '0) || tx_pending_d;
    // A clearing status read still reports the flag as it stood
    result_o.overrun_flag = (step_i.cmd == CMD_STATUS) ? overrun_q : overrun_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_holding_q  <= '0;
      tx_pending_q  <= 1'b0;
      shift_word_q  <= '0;
      bits_left_q   <= '0;
      presc_q       <= '0;
      clock_level_q <= 1'b0;
      rx_holding_q  <= '0;
      rx_full_q     <= 1'b0;
      overrun_q     <= 1'b0;
      rd_armed_q    <= 1'b0;
      miso_latch_q  <= 1'b0;
      latch_valid_q <= 1'b0;
    end else begin
      tx_holding_q  <= tx_holding_d;
      tx_pending_q  <= tx_pending_d;
      shift_word_q  <= shift_word_d;
      bits_left_q   <= bits_left_d;
      presc_q       <= presc_d;
      clock_level_q <= clock_level_d;
      rx_holding_q  <= rx_holding_d;
      rx_full_q     <= rx_full_d;
      overrun_q     <= overrun_d;
      rd_armed_q    <= rd_armed_d;
      miso_latch_q  <= miso_latch_d;
      latch_valid_q <= latch_valid_d;
    end
  end

  // Frame counter never runs past one wide frame
  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_left_q <= CntW'(MAX_FRAME_BITS))
    else $error("bits_left beyond frame length");

  // Overrun clear is only armed while overrun is set
  a_arm_implies_ovr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_armed_q |-> overrun_q)
    else $error("overrun clear armed without overrun");

  // A held MISO sample belongs to a running frame
  a_latch_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_valid_q |-> (bits_left_q != '0))
    else $error("MISO sample held with no frame running");

  // A tick on a disabled port leaves the shifter idle
  a_disable_aborts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i.valid && step_i.cmd == CMD_TICK && !cfg_i.port_enable)
      |=> (bits_left_q == '0 && !latch_valid_q))
    else $error("disabled tick left a frame running");

endmodule

FILE: src/spi_master_port_unit.sv
// SPI master port, CPOL/CPHA selectable, with streaming item channels.
// Instantiates smp_engine; depends on smp_pkg.
//
// Usage: each slave-side item is one peripheral clock cycle carrying a tick
// (tuser = tick) or a bus access (write data, read data, read status).
// tdata carries the word to send and the sampled MISO level. Every accepted
// item yields exactly one master-side item with the received word (data reads
// only, zero otherwise), the SCK and MOSI levels after the step, and the
// TXE, RXNE, BSY and OVR flags.
// The result is in the output register the cycle after acceptance.
// Throughput: one item per cycle while the output is not stalled; all step
// logic sits between the state registers and the output register.
// Stall: while the output register holds an untaken result and the receiver
// holds tready low, s_axis_tready drops; a new item is taken in the same
// cycle the held result leaves. Reset: all buffers, flags and configuration
// clear to zero; SCK idles low until polarity is written. Configuration is
// written through cfg_we_i, cfg_addr_i and cfg_wdata_i, one register per
// cycle; the user writes it only while the port is idle; not enforced.
module spi_master_port_unit #(
  parameter int unsigned MAX_FRAME_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] write_word, [16] miso_bit, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] read_word, [16] sck_level, [17] mosi_bit, [18] tx_empty,
  // [19] rx_not_empty, [20] busy_flag, [21] overrun_flag, [23:22] zero
  output logic [23:0] m_axis_tdata
);
  import smp_pkg::*;

  smp_cfg_t    cfg_q, cfg_d;
  smp_step_t   step;
  smp_result_t result;
  smp_result_t out_q;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  // Configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_BAUD:   cfg_d.baud_select    = cfg_wdata_i;
        CFG_CPOL:   cfg_d.clock_polarity = cfg_wdata_i[0];
        CFG_CPHA:   cfg_d.clock_phase    = cfg_wdata_i[0];
        CFG_LSB:    cfg_d.lsb_first      = cfg_wdata_i[0];
        CFG_WIDE:   cfg_d.wide_frame     = cfg_wdata_i[0];
        CFG_ENABLE: cfg_d.port_enable    = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Take an item whenever the output register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign step.valid      = accept;
  assign step.cmd        = smp_cmd_e'(s_axis_tuser);
  assign step.write_word = s_axis_tdata[15:0];
  assign step.miso_bit   = s_axis_tdata[16];

  smp_engine #(
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .step_i  (step),
    .result_o(result)
  );

  // Output register
  assign out_valid_d = accept || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

endmodule
